// ----- rtl/cubic_bezier_adaptive_flattener_core_assert.svh -----
// Assertion macros for the checker file of the Bezier flattener.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef CUBIC_BEZIER_ADAPTIVE_FLATTENER_CORE_ASSERT_SVH
`define CUBIC_BEZIER_ADAPTIVE_FLATTENER_CORE_ASSERT_SVH

// Concurrent check, disabled while reset is high.
`define CBF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Concurrent check that also holds across reset.
`define CBF_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ----- rtl/cbf_pkg.sv -----
// Shared types, widths and codes for the Bezier flattener.
// Used by the interfaces, controller, datapath, multiplier and top level.
package cbf_pkg;

   localparam int COORD_BITS     = 32;
   localparam int DIFF_BITS      = 33;
   localparam int LIMB_BITS      = 34;
   localparam int OPND_BITS      = 68;
   localparam int PROD_BITS      = 136;
   localparam int TOL_BITS       = 31;
   localparam int TOL2_BITS      = 62;
   localparam int DEPTH_CFG_BITS = 3;
   localparam int LEVEL_BITS     = 4;
   localparam int NUM_BITS       = 6;
   localparam int PTS_BITS       = 7;
   localparam int IDX_FIELD_BITS = 3;
   localparam int RESULT_MAX     = 64;
   localparam int CSR_ADDR_BITS  = 1;
   localparam int CSR_DATA_BITS  = 31;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOL   = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEPTH = 1'b1;

   localparam logic [TOL_BITS-1:0]       TOL_RESET   = 31'd65536;
   localparam logic [DEPTH_CFG_BITS-1:0] DEPTH_RESET = 3'd6;

   typedef logic [3:0] op_type;

   localparam op_type OP_DXX = 4'd0;
   localparam op_type OP_DYY = 4'd1;
   localparam op_type OP_TOL = 4'd2;
   localparam op_type OP_E1X = 4'd3;
   localparam op_type OP_E1Y = 4'd4;
   localparam op_type OP_E2X = 4'd5;
   localparam op_type OP_E2Y = 4'd6;
   localparam op_type OP_C1A = 4'd7;
   localparam op_type OP_C1B = 4'd8;
   localparam op_type OP_C2A = 4'd9;
   localparam op_type OP_C2B = 4'd10;
   localparam op_type OP_MM  = 4'd11;
   localparam op_type OP_TL  = 4'd12;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [7:0][COORD_BITS-1:0] seg_type;

   typedef struct packed {
      logic                      load;
      logic                      emit_start;
      logic                      emit_end;
      logic                      last;
      logic [NUM_BITS-1:0]       number;
      logic                      split;
      logic                      push;
      logic                      pop;
      logic [IDX_FIELD_BITS-1:0] idx;
      logic                      diff;
      logic                      mul_go;
      op_type                    op;
   } cbf_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic len_zero;
      logic flat_deg;
      logic flat_gen;
      logic out_busy;
   } cbf_stat_type;

endpackage

// ----- rtl/cbf_ifs.sv -----
// Valid/ready channel interfaces for curve items and polyline point items.
// Depends on cbf_pkg for the coordinate type.
interface cbf_req_if;
   import cbf_pkg::*;
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type ctrl_a_x;
   coord_type ctrl_a_y;
   coord_type ctrl_b_x;
   coord_type ctrl_b_y;
   coord_type end_x;
   coord_type end_y;
   modport source (output valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
                   end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
                 end_x, end_y, output ready);
endinterface

interface cbf_rsp_if;
   import cbf_pkg::*;
   logic                valid;
   logic                ready;
   coord_type           point_x;
   coord_type           point_y;
   logic [NUM_BITS-1:0] point_number;
   logic                last_point;
   modport source (output valid, point_x, point_y, point_number, last_point, input ready);
   modport sink (input valid, point_x, point_y, point_number, last_point, output ready);
endinterface

// ----- rtl/cbf_mul.sv -----
// Iterative unsigned multiplier, 68 x 68 bits, one 34 x 34 partial product per cycle.
// Depends on cbf_pkg for operand and product widths.
module cbf_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [cbf_pkg::OPND_BITS-1:0] a,
   input  logic [cbf_pkg::OPND_BITS-1:0] b,
   output logic                          done,
   output logic [cbf_pkg::PROD_BITS-1:0] prod
);
   import cbf_pkg::*;

   logic [OPND_BITS-1:0]   a_ff, a_in, b_ff, b_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [1:0]             step_ff, step_in;
   logic                   busy_ff, busy_in, fast_ff, fast_in, done_ff, done_in;
   logic [LIMB_BITS-1:0]   al, bl;
   logic [2*LIMB_BITS-1:0] pp;
   logic [PROD_BITS-1:0]   pp_sh;
   logic                   last_step;

   always_comb begin
      al = (step_ff == 2'd1 || step_ff == 2'd3) ? a_ff[OPND_BITS-1:LIMB_BITS]
                                                : a_ff[LIMB_BITS-1:0];
      bl = step_ff[1] ? b_ff[OPND_BITS-1:LIMB_BITS] : b_ff[LIMB_BITS-1:0];
      pp = al * bl;
      unique case (step_ff)
         2'd0:    pp_sh = PROD_BITS'(pp);
         2'd3:    pp_sh = PROD_BITS'(pp) << (2 * LIMB_BITS);
         default: pp_sh = PROD_BITS'(pp) << LIMB_BITS;
      endcase
      // With both upper limbs zero the low product is the whole answer.
      last_step = fast_ff || (step_ff == 2'd3);
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      fast_in = fast_ff;
      done_in = 1'b0;
      if (go) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
         fast_in = (a[OPND_BITS-1:LIMB_BITS] == '0) && (b[OPND_BITS-1:LIMB_BITS] == '0);
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff + 2'd1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      fast_ff <= fast_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ----- rtl/cbf_dp.sv -----
// Datapath: segment registers, pending-half stack, flatness arithmetic, output register.
// Depends on cbf_pkg and instantiates cbf_mul.
module cbf_dp #(
   parameter int DEPTH_MAX = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cbf_pkg::cbf_cmd_type         cmd,
   output cbf_pkg::cbf_stat_type        stat,
   input  cbf_pkg::seg_type             in_seg,
   input  logic [cbf_pkg::TOL_BITS-1:0] tol,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cbf_pkg::coord_type           point_x,
   output cbf_pkg::coord_type           point_y,
   output logic [cbf_pkg::NUM_BITS-1:0] point_number,
   output logic                         last_point
);
   import cbf_pkg::*;

   localparam int IDX_W = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;

   seg_type seg_ff, seg_in;
   seg_type stk_ff [DEPTH_MAX];
   seg_type left_seg, right_seg;
   logic signed [DIFF_BITS-1:0] d_ff [6];
   logic signed [DIFF_BITS-1:0] d_in [6];
   op_type op_ff;
   logic   sgn_ff;
   logic [OPND_BITS-1:0] len2_ff, len2_in, m1_ff, m1_in, m2_ff, m2_in, mmax;
   logic [TOL2_BITS-1:0] tol2_ff, tol2_in;
   logic signed [OPND_BITS:0] cr_ff, cr_in, sp, cdiff;
   logic [PROD_BITS-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in, prod;
   logic [OPND_BITS-1:0] opa, opb;
   logic                 opa_neg, opb_neg, mul_done;
   logic                 rsp_valid_ff, rsp_valid_in, last_ff;
   coord_type            px_ff, py_ff;
   logic [NUM_BITS-1:0]  num_ff;

   function automatic coord_type mid(input coord_type a, input coord_type b);
      logic signed [COORD_BITS:0] s;
      s = $signed({a[COORD_BITS-1], a}) + $signed({b[COORD_BITS-1], b});
      return s[COORD_BITS:1];
   endfunction

   function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
      return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
   endfunction

   // De Casteljau split at t = 1/2, x and y handled alike.
   always_comb begin
      coord_type q0, q1, q2, r0, r1, s;
      for (int k = 0; k < 2; k++) begin
         q0 = mid(seg_ff[k], seg_ff[2+k]);
         q1 = mid(seg_ff[2+k], seg_ff[4+k]);
         q2 = mid(seg_ff[4+k], seg_ff[6+k]);
         r0 = mid(q0, q1);
         r1 = mid(q1, q2);
         s  = mid(r0, r1);
         left_seg[k]    = seg_ff[k];
         left_seg[2+k]  = q0;
         left_seg[4+k]  = r0;
         left_seg[6+k]  = s;
         right_seg[k]   = s;
         right_seg[2+k] = r1;
         right_seg[4+k] = q2;
         right_seg[6+k] = seg_ff[6+k];
      end
   end

   // Chord and edge vectors: dx, dy, e1x, e1y, e2x, e2y.
   always_comb begin
      d_in = d_ff;
      if (cmd.diff) begin
         d_in[0] = $signed({seg_ff[6][COORD_BITS-1], seg_ff[6]})
                 - $signed({seg_ff[0][COORD_BITS-1], seg_ff[0]});
         d_in[1] = $signed({seg_ff[7][COORD_BITS-1], seg_ff[7]})
                 - $signed({seg_ff[1][COORD_BITS-1], seg_ff[1]});
         d_in[2] = $signed({seg_ff[2][COORD_BITS-1], seg_ff[2]})
                 - $signed({seg_ff[0][COORD_BITS-1], seg_ff[0]});
         d_in[3] = $signed({seg_ff[3][COORD_BITS-1], seg_ff[3]})
                 - $signed({seg_ff[1][COORD_BITS-1], seg_ff[1]});
         d_in[4] = $signed({seg_ff[4][COORD_BITS-1], seg_ff[4]})
                 - $signed({seg_ff[0][COORD_BITS-1], seg_ff[0]});
         d_in[5] = $signed({seg_ff[5][COORD_BITS-1], seg_ff[5]})
                 - $signed({seg_ff[1][COORD_BITS-1], seg_ff[1]});
      end
   end

   assign mmax = (m1_ff >= m2_ff) ? m1_ff : m2_ff;

   // Multiplier operand selection.
   always_comb begin
      opa     = '0;
      opb     = '0;
      opa_neg = 1'b0;
      opb_neg = 1'b0;
      unique case (cmd.op)
         OP_DXX: begin opa = OPND_BITS'(mag(d_ff[0])); opb = opa; end
         OP_DYY: begin opa = OPND_BITS'(mag(d_ff[1])); opb = opa; end
         OP_TOL: begin opa = OPND_BITS'(tol); opb = opa; end
         OP_E1X: begin opa = OPND_BITS'(mag(d_ff[2])); opb = opa; end
         OP_E1Y: begin opa = OPND_BITS'(mag(d_ff[3])); opb = opa; end
         OP_E2X: begin opa = OPND_BITS'(mag(d_ff[4])); opb = opa; end
         OP_E2Y: begin opa = OPND_BITS'(mag(d_ff[5])); opb = opa; end
         OP_C1A: begin
            opa = OPND_BITS'(mag(d_ff[0])); opb = OPND_BITS'(mag(d_ff[3]));
            opa_neg = d_ff[0][DIFF_BITS-1]; opb_neg = d_ff[3][DIFF_BITS-1];
         end
         OP_C1B: begin
            opa = OPND_BITS'(mag(d_ff[1])); opb = OPND_BITS'(mag(d_ff[2]));
            opa_neg = d_ff[1][DIFF_BITS-1]; opb_neg = d_ff[2][DIFF_BITS-1];
         end
         OP_C2A: begin
            opa = OPND_BITS'(mag(d_ff[0])); opb = OPND_BITS'(mag(d_ff[5]));
            opa_neg = d_ff[0][DIFF_BITS-1]; opb_neg = d_ff[5][DIFF_BITS-1];
         end
         OP_C2B: begin
            opa = OPND_BITS'(mag(d_ff[1])); opb = OPND_BITS'(mag(d_ff[4]));
            opa_neg = d_ff[1][DIFF_BITS-1]; opb_neg = d_ff[4][DIFF_BITS-1];
         end
         OP_MM:  begin opa = mmax; opb = mmax; end
         OP_TL:  begin opa = OPND_BITS'(tol2_ff); opb = len2_ff; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   cbf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (cmd.mul_go),
      .a     (opa),
      .b     (opb),
      .done  (mul_done),
      .prod  (prod)
   );

   // Signed cross-product term; its magnitude stays far below 2^67.
   always_comb begin
      sp    = sgn_ff ? -$signed({2'b00, prod[OPND_BITS-2:0]})
                     :  $signed({2'b00, prod[OPND_BITS-2:0]});
      cdiff = cr_ff - sp;
   end

   always_comb begin
      len2_in = len2_ff;
      tol2_in = tol2_ff;
      m1_in   = m1_ff;
      m2_in   = m2_ff;
      cr_in   = cr_ff;
      lhs_in  = lhs_ff;
      rhs_in  = rhs_ff;
      if (mul_done) begin
         unique case (op_ff)
            OP_DXX:  len2_in = prod[OPND_BITS-1:0];
            OP_DYY:  len2_in = len2_ff + prod[OPND_BITS-1:0];
            OP_TOL:  tol2_in = prod[TOL2_BITS-1:0];
            OP_E1X:  m1_in = prod[OPND_BITS-1:0];
            OP_E1Y:  m1_in = m1_ff + prod[OPND_BITS-1:0];
            OP_E2X:  m2_in = prod[OPND_BITS-1:0];
            OP_E2Y:  m2_in = m2_ff + prod[OPND_BITS-1:0];
            OP_C1A:  cr_in = sp;
            OP_C1B:  m1_in = cdiff[OPND_BITS] ? OPND_BITS'(-cdiff) : OPND_BITS'(cdiff);
            OP_C2A:  cr_in = sp;
            OP_C2B:  m2_in = cdiff[OPND_BITS] ? OPND_BITS'(-cdiff) : OPND_BITS'(cdiff);
            OP_MM:   lhs_in = prod;
            OP_TL:   rhs_in = prod;
            default: lhs_in = lhs_ff;
         endcase
      end
   end

   always_comb begin
      seg_in = seg_ff;
      if (cmd.load) begin
         seg_in = in_seg;
      end else if (cmd.split) begin
         seg_in = left_seg;
      end else if (cmd.pop) begin
         seg_in = stk_ff[cmd.idx[IDX_W-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_start || cmd.emit_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff  <= seg_in;
      d_ff    <= d_in;
      len2_ff <= len2_in;
      tol2_ff <= tol2_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      cr_ff   <= cr_in;
      lhs_ff  <= lhs_in;
      rhs_ff  <= rhs_in;
      if (cmd.mul_go) begin
         op_ff  <= cmd.op;
         sgn_ff <= opa_neg ^ opb_neg;
      end
      if (cmd.split && cmd.push) begin
         stk_ff[cmd.idx[IDX_W-1:0]] <= right_seg;
      end
      if (cmd.emit_start || cmd.emit_end) begin
         px_ff   <= cmd.emit_start ? seg_ff[0] : seg_ff[6];
         py_ff   <= cmd.emit_start ? seg_ff[1] : seg_ff[7];
         num_ff  <= cmd.number;
         last_ff <= cmd.last;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.mul_done = mul_done;
   assign stat.len_zero = (len2_ff == '0);
   assign stat.flat_deg = (mmax <= OPND_BITS'(tol2_ff));
   assign stat.flat_gen = (lhs_ff <= rhs_ff);
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign point_x      = px_ff;
   assign point_y      = py_ff;
   assign point_number = num_ff;
   assign last_point   = last_ff;
endmodule

// ----- rtl/cbf_ctrl.sv -----
// Controller: walks the subdivision tree and sequences the flatness products.
// Depends on cbf_pkg; drives cbf_dp through the command struct.
module cbf_ctrl #(
   parameter int POINT_CAP = 64,
   parameter int DEPTH_MAX = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cbf_pkg::DEPTH_CFG_BITS-1:0] depth_limit,
   input  cbf_pkg::cbf_stat_type              stat,
   output cbf_pkg::cbf_cmd_type               cmd
);
   import cbf_pkg::*;

   localparam int IDX_W = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
   localparam int CAP   = (POINT_CAP < RESULT_MAX) ? POINT_CAP : RESULT_MAX;
   localparam logic [PTS_BITS-1:0]   CAP_V   = PTS_BITS'(CAP);
   localparam logic [LEVEL_BITS-1:0] DMAX_V  = LEVEL_BITS'(DEPTH_MAX);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_DIFF   = 3'd3;
   localparam logic [2:0] S_MGO    = 3'd4;
   localparam logic [2:0] S_MWAIT  = 3'd5;
   localparam logic [2:0] S_DECIDE = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0]            state_ff, state_in;
   op_type                op_ff, op_in, op_next;
   logic [LEVEL_BITS-1:0] level_ff, level_in, fill_ff, fill_in, fill_m1, limit;
   logic [PTS_BITS-1:0]   pts_ff, pts_in, pts_p1;
   logic [LEVEL_BITS-1:0] lvl_ff [DEPTH_MAX];
   logic                  lvl_we, is_last, flat;

   assign limit   = ({1'b0, depth_limit} < DMAX_V) ? {1'b0, depth_limit} : DMAX_V;
   assign fill_m1 = fill_ff - 1'b1;
   assign pts_p1  = pts_ff + 1'b1;
   assign is_last = (fill_ff == '0) || (pts_p1 == CAP_V);
   assign flat    = stat.len_zero ? stat.flat_deg : stat.flat_gen;

   // Product order: chord length, tolerance, then either the edge lengths
   // (zero-length chord) or the two cross products and the final compare terms.
   always_comb begin
      unique case (op_ff)
         OP_DXX:  op_next = OP_DYY;
         OP_DYY:  op_next = OP_TOL;
         OP_TOL:  op_next = stat.len_zero ? OP_E1X : OP_C1A;
         OP_E1X:  op_next = OP_E1Y;
         OP_E1Y:  op_next = OP_E2X;
         OP_E2X:  op_next = OP_E2Y;
         OP_C1A:  op_next = OP_C1B;
         OP_C1B:  op_next = OP_C2A;
         OP_C2A:  op_next = OP_C2B;
         OP_C2B:  op_next = OP_MM;
         OP_MM:   op_next = OP_TL;
         default: op_next = OP_DXX;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      level_in  = level_ff;
      fill_in   = fill_ff;
      pts_in    = pts_ff;
      lvl_we    = 1'b0;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               level_in = '0;
               fill_in  = '0;
               pts_in   = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (!stat.out_busy) begin
               cmd.emit_start = 1'b1;
               cmd.number     = '0;
               pts_in         = PTS_BITS'(1);
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = (level_ff >= limit) ? S_EMIT : S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            op_in    = OP_DXX;
            state_in = S_MGO;
         end
         S_MGO: begin
            cmd.mul_go = 1'b1;
            state_in   = S_MWAIT;
         end
         S_MWAIT: begin
            if (stat.mul_done) begin
               if (op_ff == OP_E2Y || op_ff == OP_TL) begin
                  state_in = S_DECIDE;
               end else begin
                  op_in    = op_next;
                  state_in = S_MGO;
               end
            end
         end
         S_DECIDE: begin
            if (flat) begin
               state_in = S_EMIT;
            end else begin
               cmd.split = 1'b1;
               cmd.idx   = IDX_FIELD_BITS'(fill_ff);
               if (fill_ff < DMAX_V) begin
                  cmd.push = 1'b1;
                  lvl_we   = 1'b1;
                  fill_in  = fill_ff + 1'b1;
               end
               level_in = level_ff + 1'b1;
               state_in = S_CHECK;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit_end = 1'b1;
               cmd.number   = pts_ff[NUM_BITS-1:0];
               cmd.last     = is_last;
               pts_in       = pts_p1;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  cmd.idx  = IDX_FIELD_BITS'(fill_m1);
                  fill_in  = fill_m1;
                  level_in = lvl_ff[fill_m1[IDX_W-1:0]];
                  state_in = S_CHECK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      level_ff <= level_in;
      fill_ff  <= fill_in;
      pts_ff   <= pts_in;
      if (lvl_we) begin
         lvl_ff[fill_ff[IDX_W-1:0]] <= level_ff + 1'b1;
      end
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/cubic_bezier_adaptive_flattener_core.sv -----
// Cubic Bezier flattener. One curve item in (four Q16.16 control points), a polyline
// of point items out: the start point, then the end point of every leaf segment of a
// depth-first midpoint subdivision, the last one flagged. A segment ends the descent at
// the configured depth or when its control points lie within flat_tolerance of the
// chord. Each tested segment waits on the shared 34 x 34 bit multiplier, which forms
// the up to nine flatness products one partial product a cycle; a segment at the depth
// limit needs no products. A curve walked to depth six visits up to 127 segments. A
// new curve is taken once the previous one has finished; it may be taken while the
// previous last point still waits in the output register. Configuration writes belong
// between curves.
module cubic_bezier_adaptive_flattener_core #(
   parameter int POINT_CAP = 64,
   parameter int DEPTH_MAX = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   cbf_req_if.sink                           req_bus,
   cbf_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [cbf_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [cbf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cbf_pkg::*;

   logic [TOL_BITS-1:0]       tol_ff;
   logic [DEPTH_CFG_BITS-1:0] depth_ff;
   cbf_cmd_type               cmd;
   cbf_stat_type              stat;
   seg_type                   in_seg;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         depth_ff <= DEPTH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TOL:   tol_ff   <= csr_wdata[TOL_BITS-1:0];
            CSR_DEPTH: depth_ff <= csr_wdata[DEPTH_CFG_BITS-1:0];
            default:   tol_ff   <= tol_ff;
         endcase
      end
   end

   assign in_seg[0] = req_bus.start_x;
   assign in_seg[1] = req_bus.start_y;
   assign in_seg[2] = req_bus.ctrl_a_x;
   assign in_seg[3] = req_bus.ctrl_a_y;
   assign in_seg[4] = req_bus.ctrl_b_x;
   assign in_seg[5] = req_bus.ctrl_b_y;
   assign in_seg[6] = req_bus.end_x;
   assign in_seg[7] = req_bus.end_y;

   cbf_ctrl #(
      .POINT_CAP (POINT_CAP),
      .DEPTH_MAX (DEPTH_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .depth_limit (depth_ff),
      .stat        (stat),
      .cmd         (cmd)
   );

   cbf_dp #(
      .DEPTH_MAX (DEPTH_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_seg       (in_seg),
      .tol          (tol_ff),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .point_x      (rsp_bus.point_x),
      .point_y      (rsp_bus.point_y),
      .point_number (rsp_bus.point_number),
      .last_point   (rsp_bus.last_point)
   );
endmodule

// ----- rtl/cbf_checker.sv -----
// Port-level checks for the Bezier flattener, bound to the top level.
// Depends on cbf_pkg and the assertion macro header.
`include "cubic_bezier_adaptive_flattener_core_assert.svh"

module cbf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input cbf_pkg::coord_type           point_x,
   input cbf_pkg::coord_type           point_y,
   input logic [cbf_pkg::NUM_BITS-1:0] point_number,
   input logic                         last_point
);
   import cbf_pkg::*;

   // A stalled point item keeps its contents.
   `CBF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y) && $stable(point_number) && $stable(last_point))
   // The start point is never the final point of a curve.
   `CBF_ASSERT(a_first_not_last, clock, reset, rsp_valid && point_number == '0 |-> !last_point)
   // Once a curve is taken the block does not accept another in the next cycle.
   `CBF_ASSERT(a_busy_after_take, clock, reset, req_valid && req_ready |=> !req_ready)
   // Reset leaves no point item pending.
   `CBF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)
endmodule

bind cubic_bezier_adaptive_flattener_core cbf_checker u_cbf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .point_x      (rsp_bus.point_x),
   .point_y      (rsp_bus.point_y),
   .point_number (rsp_bus.point_number),
   .last_point   (rsp_bus.last_point)
);
